[src/state_variable_filter_2x_core_defines.svh]
// Assertion macros shared by the state variable filter RTL.
`ifndef STATE_VARIABLE_FILTER_2X_CORE_DEFINES_SVH
`define STATE_VARIABLE_FILTER_2X_CORE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define SVF2X_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define SVF2X_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/svf2x_pkg.sv]
// Types, operation codes and fixed constants of the state variable filter.
package svf2x_pkg;

  typedef logic signed [17:0] sample_t;
  typedef logic        [16:0] coef_t;
  typedef logic signed [31:0] acc_t;
  typedef logic        [1:0]  mode_t;
  typedef logic        [2:0]  op_t;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 17;
  localparam int RES_W       = 33;

  localparam logic [CFG_INDEX_W-1:0] REG_RESPONSE_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_GAIN    = 1'd1;

  localparam mode_t MODE_LOWPASS  = 2'd0;
  localparam mode_t MODE_HIGHPASS = 2'd1;
  localparam mode_t MODE_BANDPASS = 2'd2;
  localparam mode_t MODE_NOTCH    = 2'd3;

  // Products issued to the shared multiplier.
  localparam op_t OP_NONE  = 3'd0;
  localparam op_t OP_SHAPE = 3'd1;
  localparam op_t OP_GX    = 3'd2;
  localparam op_t OP_S99   = 3'd3;
  localparam op_t OP_T1    = 3'd4;
  localparam op_t OP_DAMP  = 3'd5;
  localparam op_t OP_T2    = 3'd6;
  localparam op_t OP_T3    = 3'd7;

  localparam coef_t COEF_ONE = 17'd65536;
  localparam coef_t K_015    = 17'd9830;
  localparam coef_t K_085    = 17'd55706;
  localparam coef_t K_099    = 17'd64881;
  localparam coef_t DAMP_MIN = 17'd655;

  typedef struct packed {
    logic ready;
    op_t  issue;
    logic out_load;
  } ctl_t;

  function automatic coef_t clamp_coef(input coef_t v);
    return (v > COEF_ONE) ? COEF_ONE : v;
  endfunction

endpackage

[src/svf2x_in_if.sv]
// Input channel: one sample with its cutoff and resonance coefficients.
interface svf2x_in_if;
  import svf2x_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;
  coef_t   cutoff_coef;
  coef_t   resonance_coef;

  modport source (output valid, output sample_in, output cutoff_coef,
                  output resonance_coef, input ready);
  modport sink (input valid, input sample_in, input cutoff_coef,
                input resonance_coef, output ready);
endinterface

[src/svf2x_out_if.sv]
// Output channel: one filtered sample.
interface svf2x_out_if;
  import svf2x_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

[src/state_variable_filter_2x_core.sv]
// Top level of the oversampled two-pole state variable filter.
//
// in_stream carries one sample with its own cutoff and resonance; a
// transfer happens when valid and ready are both high. out_stream returns
// one filtered sample for every input transfer, in order.
// cfg_write with cfg_index writes response_mode (0) or input_gain (1);
// write only while the block is idle.
// Each sample is carried from its input transfer to the output register
// by the sequencer, which runs all of its products through one shared
// multiplier. ready is high only while the sequencer is idle, so a new
// sample can be taken in the cycle after the output register loads.
// The output register holds a result until it is taken; the block still
// accepts and computes the next sample, then waits to load it.
// Reset clears the filter states, the previous sample, both registers and
// the output valid flag.
`include "state_variable_filter_2x_core_defines.svh"

module state_variable_filter_2x_core #(
  parameter int OVERSAMPLE_PASSES = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  svf2x_in_if.sink                            in_stream,
  svf2x_out_if.source                         out_stream,
  input  logic                                cfg_write,
  input  logic [svf2x_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [svf2x_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import svf2x_pkg::*;

  // Interpolation by 1/OVERSAMPLE_PASSES: the running step sum is biased to
  // a positive value and divided by a reciprocal multiply that is exact
  // for every value it can take.
  localparam int DIV_SHIFT = 26;
  localparam logic [23:0] NBIAS = 24'(OVERSAMPLE_PASSES * (1 << 21));
  localparam logic [26:0] RECIP =
    27'(((64'd1 << DIV_SHIFT) + 64'(OVERSAMPLE_PASSES) - 64'd1) /
        64'(OVERSAMPLE_PASSES));

  ctl_t ctl;

  mode_t   response_mode;
  coef_t   input_gain;
  sample_t previous_sample;
  acc_t    lowpass_acc;
  acc_t    highpass_acc;
  acc_t    bandpass_acc;
  acc_t    notch_acc;

  sample_t            x;
  coef_t              c;
  coef_t              r;
  logic signed [18:0] diff;
  logic signed [21:0] n;
  sample_t            xk;
  sample_t            gx;
  coef_t              shape;
  logic        [15:0] shape99;
  coef_t              damp;

  coef_t                    mul_a;
  logic signed [31:0]       mul_b;
  logic signed [RES_W-1:0]  res;
  op_t                      res_op;

  logic               in_fire;
  logic signed [18:0] diff_now;
  logic        [23:0] nb;
  logic        [50:0] q_prod;
  logic        [24:0] xk_wide;
  acc_t               sel;
  logic               out_valid;
  sample_t            sample_out;

  function automatic acc_t sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  svf2x_ctrl #(
    .PASSES(OVERSAMPLE_PASSES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_stream.valid),
    .out_free (!out_valid || out_stream.ready),
    .ctl      (ctl)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.issue)
      OP_SHAPE: begin
        mul_a = c;
        mul_b = 32'(K_015);
      end
      OP_GX: begin
        mul_a = input_gain;
        mul_b = 32'(xk);
      end
      OP_S99: begin
        mul_a = shape;
        mul_b = 32'(K_099);
      end
      OP_T1: begin
        mul_a = c;
        mul_b = bandpass_acc;
      end
      OP_DAMP: begin
        mul_a = r;
        mul_b = {16'd0, shape99};
      end
      OP_T2: begin
        mul_a = damp;
        mul_b = bandpass_acc;
      end
      OP_T3: begin
        mul_a = c;
        mul_b = highpass_acc;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  svf2x_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .a      (mul_a),
    .b      (mul_b),
    .op     (ctl.issue),
    .res    (res),
    .res_op (res_op)
  );

  assign in_fire  = in_stream.valid && ctl.ready;
  assign diff_now = 19'(in_stream.sample_in) - 19'(previous_sample);

  // Pass input: previous sample plus the floored fraction of the step.
  assign nb      = 24'(n) + NBIAS;
  assign q_prod  = 51'(nb) * 51'(RECIP);
  assign xk_wide = 25'(previous_sample) + {1'b0, q_prod[DIV_SHIFT +: 24]} - 25'(1 << 21);

  always_ff @(posedge clk) begin
    xk <= xk_wide[17:0];
    if (in_fire) begin
      x    <= in_stream.sample_in;
      c    <= clamp_coef(in_stream.cutoff_coef);
      r    <= clamp_coef(in_stream.resonance_coef);
      diff <= diff_now;
      n    <= 22'(diff_now);
    end
    case (res_op)
      OP_SHAPE: shape   <= K_085 + res[16:0];
      OP_GX: begin
        gx <= res[17:0];
        n  <= n + 22'(diff);
      end
      OP_S99:   shape99 <= res[15:0];
      OP_DAMP:  damp    <= COEF_ONE - res[16:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowpass_acc     <= '0;
      highpass_acc    <= '0;
      bandpass_acc    <= '0;
      notch_acc       <= '0;
      previous_sample <= '0;
    end else begin
      case (res_op)
        OP_T1: lowpass_acc <= sat32(35'(lowpass_acc) + 35'(res));
        OP_T2: highpass_acc <= sat32(35'(gx) - 35'(lowpass_acc) - 35'(res));
        OP_T3: begin
          bandpass_acc <= sat32(35'(bandpass_acc) + 35'(res));
          notch_acc    <= sat32(35'(highpass_acc) + 35'(lowpass_acc));
        end
        default: begin
        end
      endcase
      if (ctl.out_load) begin
        previous_sample <= x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response_mode <= MODE_LOWPASS;
      input_gain    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RESPONSE_MODE: response_mode <= cfg_data[1:0];
        REG_INPUT_GAIN:    input_gain    <= clamp_coef(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (response_mode)
      MODE_LOWPASS:  sel = lowpass_acc;
      MODE_HIGHPASS: sel = highpass_acc;
      MODE_BANDPASS: sel = bandpass_acc;
      MODE_NOTCH:    sel = notch_acc;
      default:       sel = notch_acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      if (sel > 32'sd131071) begin
        sample_out <= 18'sd131071;
      end else if (sel < -32'sd131072) begin
        sample_out <= -18'sd131072;
      end else begin
        sample_out <= sel[17:0];
      end
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign in_stream.ready       = ctl.ready;
  assign out_stream.valid      = out_valid;
  assign out_stream.sample_out = sample_out;

  `SVF2X_ASSERT_NEXT(a_busy_after_take, in_fire, !in_stream.ready,
    "input taken while a sample is still in work")
  `SVF2X_ASSERT_SAME(a_load_after_drain, ctl.out_load, res_op == OP_NONE,
    "output loaded while a product is still pending")
  `SVF2X_ASSERT_SAME(a_damp_range, ctl.issue == OP_T2,
    (damp >= DAMP_MIN) && (damp <= COEF_ONE),
    "damping coefficient out of range")
endmodule

[src/svf2x_mul.sv]
// Shared multiplier with a registered product and round-half-up shift.
module svf2x_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  svf2x_pkg::coef_t         a,
  input  logic signed [31:0]       b,
  input  svf2x_pkg::op_t           op,
  output logic signed [svf2x_pkg::RES_W-1:0] res,
  output svf2x_pkg::op_t           res_op
);
  import svf2x_pkg::*;

  logic signed [49:0] prod;
  logic signed [49:0] rounded;
  logic signed [49:0] shifted;
  logic               half17;

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, a}) * b;
    if (rst) begin
      res_op <= OP_NONE;
    end else begin
      res_op <= op;
    end
  end

  // The two integrator products by the cutoff carry the extra halving of the step size.
  assign half17  = (res_op == OP_T1) || (res_op == OP_T3);
  assign rounded = prod + (half17 ? 50'sd65536 : 50'sd32768);
  assign shifted = half17 ? (rounded >>> 17) : (rounded >>> 16);
  assign res     = shifted[RES_W-1:0];
endmodule

[src/svf2x_ctrl.sv]
// Sequencer that orders the products of one sample through the multiplier.
module svf2x_ctrl #(
  parameter int PASSES = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_free,
  output svf2x_pkg::ctl_t ctl
);
  import svf2x_pkg::*;

  localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(PASSES - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_C0   = 4'd1;
  localparam logic [3:0] S_C1   = 4'd2;
  localparam logic [3:0] S_C2   = 4'd3;
  localparam logic [3:0] S_C3   = 4'd4;
  localparam logic [3:0] S_C4   = 4'd5;
  localparam logic [3:0] S_C5   = 4'd6;
  localparam logic [3:0] S_D2   = 4'd7;
  localparam logic [3:0] S_P1   = 4'd8;
  localparam logic [3:0] S_P2   = 4'd9;
  localparam logic [3:0] S_P3   = 4'd10;
  localparam logic [3:0] S_P4   = 4'd11;
  localparam logic [3:0] S_P5   = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [PASS_W-1:0] pass;
  logic [PASS_W-1:0] pass_next;

  always_comb begin
    state_next   = state;
    pass_next    = pass;
    ctl.ready    = 1'b0;
    ctl.issue    = OP_NONE;
    ctl.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        ctl.ready = 1'b1;
        if (in_valid) begin
          state_next = S_C0;
          pass_next  = '0;
        end
      end
      S_C0: begin
        ctl.issue  = OP_SHAPE;
        state_next = S_C1;
      end
      S_C1: begin
        ctl.issue  = OP_GX;
        state_next = S_C2;
      end
      S_C2: begin
        ctl.issue  = OP_S99;
        state_next = S_C3;
      end
      S_C3: begin
        ctl.issue  = OP_T1;
        state_next = S_C4;
      end
      S_C4: begin
        ctl.issue  = OP_DAMP;
        state_next = S_C5;
      end
      S_C5: begin
        state_next = S_D2;
      end
      S_D2: begin
        ctl.issue  = OP_T2;
        state_next = S_P3;
      end
      S_P1: begin
        ctl.issue  = OP_T1;
        state_next = S_P2;
      end
      S_P2: begin
        ctl.issue  = OP_T2;
        state_next = S_P3;
      end
      S_P3: begin
        state_next = S_P4;
      end
      S_P4: begin
        ctl.issue  = OP_T3;
        state_next = S_P5;
      end
      S_P5: begin
        if (pass == LAST_PASS) begin
          state_next = S_FIN;
        end else begin
          // The next pass input does not depend on the bandpass update.
          ctl.issue  = OP_GX;
          pass_next  = pass + 1'b1;
          state_next = S_P1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= '0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end
endmodule

[verif/tb_state_variable_filter_2x_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the oversampled state variable filter core.
module tb_state_variable_filter_2x_core;
  import svf2x_pkg::*;

  localparam int PASSES      = 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 24;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  svf2x_in_if  in_bus ();
  svf2x_out_if out_bus ();

  state_variable_filter_2x_core #(
    .OVERSAMPLE_PASSES(PASSES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_bus),
    .out_stream(out_bus),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Filter model state and register copies.
  longint lp_state, hp_state, bp_state, notch_state, prev_sample;
  mode_t  model_mode;
  longint model_gain;

  sample_t     expected_out_q[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_state_variable_filter_2x_core failed");
      $finish;
    end
  end

  function automatic longint round_shr(longint p, int s);
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint floor_quot(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint sat_acc(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint limit_coef(longint v);
    return (v > longint'(COEF_ONE)) ? longint'(COEF_ONE) : v;
  endfunction

  // Runs all oversampled passes for one sample and returns the selected state.
  function automatic sample_t predict_filter_output(sample_t s, coef_t cc, coef_t rc);
    longint x, c, r, shape, s99, damp, diff, xk, gx, sel;
    x     = longint'(s);
    c     = limit_coef(longint'(cc));
    r     = limit_coef(longint'(rc));
    shape = longint'(K_085) + round_shr(longint'(K_015) * c, 16);
    s99   = round_shr(longint'(K_099) * shape, 16);
    damp  = longint'(COEF_ONE) - round_shr(r * s99, 16);
    diff  = x - prev_sample;
    for (int k = 0; k < PASSES; k++) begin
      xk          = prev_sample + floor_quot(diff * (k + 1), PASSES);
      gx          = round_shr(model_gain * xk, 16);
      lp_state    = sat_acc(lp_state + round_shr(c * bp_state, 17));
      hp_state    = sat_acc(gx - lp_state - round_shr(damp * bp_state, 16));
      bp_state    = sat_acc(round_shr(c * hp_state, 17) + bp_state);
      notch_state = sat_acc(hp_state + lp_state);
    end
    prev_sample = x;
    case (model_mode)
      MODE_LOWPASS: begin
        sel = lp_state;
      end
      MODE_HIGHPASS: begin
        sel = hp_state;
      end
      MODE_BANDPASS: begin
        sel = bp_state;
      end
      default: begin
        sel = notch_state;
      end
    endcase
    if (sel > 131071) sel = 131071;
    if (sel < -131072) sel = -131072;
    return sample_t'(sel);
  endfunction

  // Output side: random back-pressure unless a steady stretch is running.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (expected_out_q.size() == 0) begin
        $error("sample_out: no result expected, actual %0d", out_bus.sample_out);
        mismatch_count <= mismatch_count + 1;
      end else if (out_bus.sample_out !== expected_out_q[0]) begin
        $error("sample_out: expected %0d, actual %0d", expected_out_q[0],
               out_bus.sample_out);
        mismatch_count <= mismatch_count + 1;
        void'(expected_out_q.pop_front());
      end else begin
        void'(expected_out_q.pop_front());
      end
    end
  end

  // Leaves valid high after the transfer so that back-to-back items keep it up.
  task automatic send_sample(int s, int unsigned c, int unsigned r);
    if (!steady && $urandom_range(0, 99) < 34) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 34);
    end
    in_bus.valid          <= 1'b1;
    in_bus.sample_in      <= sample_t'(s);
    in_bus.cutoff_coef    <= coef_t'(c);
    in_bus.resonance_coef <= coef_t'(r);
    do @(posedge clk); while (!in_bus.ready);
    expected_out_q.push_back(predict_filter_output(sample_t'(s), coef_t'(c), coef_t'(r)));
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_RESPONSE_MODE) model_mode = mode_t'(data);
    else model_gain = limit_coef(longint'(data & 32'h1FFFF));
    @(posedge clk);
  endtask

  // With the reset gain of zero the filter must stay silent.
  task automatic test_reset_defaults();
    send_sample(131071, 65536, 65536);
    send_sample(-131072, 30000, 0);
    wait_idle();
  endtask

  task automatic test_response_modes();
    write_reg(REG_INPUT_GAIN, 65536);
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_RESPONSE_MODE, m);
      send_sample((m % 2 == 0) ? 100000 : -100000, 20000, 40000);
      wait_idle();
    end
  endtask

  // Coefficients at zero, one, and above one where they clamp.
  task automatic test_coef_extremes();
    write_reg(REG_RESPONSE_MODE, MODE_BANDPASS);
    write_reg(REG_INPUT_GAIN, 32'h1FFFF);
    send_sample(70000, 0, 0);
    send_sample(-70000, 65536, 65536);
    send_sample(50000, 32'h1FFFF, 32'h1FFFF);
    send_sample(-50000, 65537, 0);
    send_sample(1, 0, 32'h10001);
    send_sample(0, 32'h1FFFF, 65536);
    wait_idle();
  endtask

  // Full-scale steps and odd differences whose midpoint rounds down.
  task automatic test_sample_extremes();
    write_reg(REG_RESPONSE_MODE, MODE_HIGHPASS);
    write_reg(REG_INPUT_GAIN, 65536);
    send_sample(-131072, 65536, 0);
    send_sample(131071, 65536, 0);
    send_sample(-3, 40000, 20000);
    send_sample(0, 40000, 20000);
    send_sample(-1, 40000, 20000);
    wait_idle();
  endtask

  // Maximum resonance driven near its peak to push the states toward their limits.
  task automatic test_resonance_drive();
    write_reg(REG_RESPONSE_MODE, MODE_NOTCH);
    for (int i = 0; i < 8; i++) send_sample((i % 2) ? -131072 : 131071, 65536, 65536);
    wait_idle();
  endtask

  task automatic test_random(int total);
    int          sent;
    int          seg_len;
    int          half;
    int          amp;
    int          s;
    int unsigned c_seg;
    int unsigned r_seg;
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_RESPONSE_MODE, (phase < 4) ? phase : $urandom_range(0, 3));
      case (phase)
        0: write_reg(REG_INPUT_GAIN, 65536);
        1: write_reg(REG_INPUT_GAIN, 32'h1FFFF);
        3: write_reg(REG_INPUT_GAIN, 0);
        default: write_reg(REG_INPUT_GAIN, $urandom_range(0, 32'h1FFFF));
      endcase
      steady = (phase == 2);
      while (sent < (total * (phase + 1)) / 6) begin
        if ($urandom_range(0, 99) < 20) begin
          send_sample($urandom_range(0, 32'h3FFFF), $urandom_range(0, 32'h1FFFF),
                      $urandom_range(0, 32'h1FFFF));
          sent++;
        end else begin
          seg_len = $urandom_range(8, 32);
          half    = $urandom_range(1, 8);
          amp     = $urandom_range(0, 131071);
          c_seg   = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 65536)
                                                 : $urandom_range(0, 32'h1FFFF);
          r_seg   = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 65536)
                                                 : $urandom_range(0, 32'h1FFFF);
          for (int i = 0; i < seg_len; i++) begin
            s = (((i / half) % 2) != 0) ? -amp : amp;
            s = s + $urandom_range(0, 63) - 32;
            if (s > 131071) s = 131071;
            if (s < -131072) s = -131072;
            send_sample(s, c_seg, r_seg);
            sent++;
          end
        end
      end
      steady = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    int drain;
    rst                   = 1'b1;
    cfg_write             = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    in_bus.valid          = 1'b0;
    in_bus.sample_in      = '0;
    in_bus.cutoff_coef    = '0;
    in_bus.resonance_coef = '0;
    steady                = 1'b0;
    mismatch_count        = 0;
    cycle_count           = 0;
    lp_state              = 0;
    hp_state              = 0;
    bp_state              = 0;
    notch_state           = 0;
    prev_sample           = 0;
    model_mode            = MODE_LOWPASS;
    model_gain            = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_response_modes();
    test_coef_extremes();
    test_sample_extremes();
    test_resonance_drive();
    test_random(500);

    in_bus.valid <= 1'b0;
    drain = 0;
    while (expected_out_q.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE) @(posedge clk);
    if (expected_out_q.size() != 0) begin
      $error("sample_out: %0d results never arrived", expected_out_q.size());
      mismatch_count = mismatch_count + 1;
    end
    if (mismatch_count == 0) begin
      $display("tb_state_variable_filter_2x_core passed");
    end else begin
      $display("tb_state_variable_filter_2x_core failed");
    end
    $finish;
  end

endmodule
